// ===== design/pbrq_pkg.sv =====
`default_nettype none
package pbrq_pkg;
   localparam int TASK_W = 6;
   localparam int PRIO_W = 5;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [OPCODE_W-1:0] OP_WAKE    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_BLOCK   = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SUSPEND = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_RESUME  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CREATE  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_CHPRIO  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SWITCH  = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IDLE_REF = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   localparam logic [1:0] REG_IDLE_TASK = 2'd0;
endpackage
`default_nettype wire

// ===== design/pbrq_req_if.sv =====
`default_nettype none
interface pbrq_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [5:0] task_id;
   logic [4:0] new_priority;
   modport source (output valid, opcode, task_id, new_priority, input ready);
   modport sink (input valid, opcode, task_id, new_priority, output ready);
endinterface
`default_nettype wire

// ===== design/pbrq_rsp_if.sv =====
`default_nettype none
interface pbrq_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] running_task;
   logic       resched_hint;
   logic [1:0] status;
   modport source (output valid, running_task, resched_hint, status, input ready);
   modport sink (input valid, running_task, resched_hint, status, output ready);
endinterface
`default_nettype wire

// ===== design/pbrq_ram.sv =====
`default_nettype none
module pbrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ===== design/priority_bitmap_run_queue.sv =====
`default_nettype none
// Channel   Direction  Payload
// req       in         opcode, task_id, new_priority
// rsp       out        running_task, resched_hint, status
// csr       in/out     APB register idle_task at byte address 0
//
// A sequencer walks the task and level memories, one synchronous read and one write
// per memory per cycle. A flags-only command goes from decode straight to the result
// step; an unlink passes S_UNL1 and S_UNL2, a link S_ENQ and S_ENQ2, and a switch scans
// the bitmap in S_SCAN, testing one level per cycle, then reads the head in S_SW/S_SW2.
// The next item is taken in the cycle after the result is registered.
// A result held by the receiver lets one more item in, which then waits in its last step.
// After reset a clearing pass over the TASK_SLOTS slots zeroes the task flags and
// priority memory, task 0 aside; no item is accepted during it, register writes are.
module priority_bitmap_run_queue
   import pbrq_pkg::*;
#(
   parameter int TASK_SLOTS = 64,
   parameter int PRIORITY_LEVELS = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pbrq_req_if.sink    req,
   pbrq_rsp_if.source  rsp,
   input  wire logic   csr_psel,
   input  wire logic   csr_penable,
   input  wire logic   csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int TW = $clog2(TASK_SLOTS);
   localparam int LW = $clog2(PRIORITY_LEVELS);
   localparam int TWP = TW + 1;
   localparam logic [LW-1:0] IDLE_LVL = LW'(PRIORITY_LEVELS - 1);
   localparam int FLAG_Q = 0;
   localparam int FLAG_W = 1;
   localparam int FLAG_S = 2;

   // Task ids are folded into the slot range by a small constant table.
   function automatic logic [TW-1:0] slot_of(input logic [TASK_W-1:0] id);
      logic [TW-1:0] r;
      r = '0;
      for (int i = 0; i < (1 << TASK_W); i++) begin
         if (id == TASK_W'(i)) r = TW'(i % TASK_SLOTS);
      end
      return r;
   endfunction

   typedef enum logic [11:0] {
      S_CLEAR = 12'b000000000001,
      S_IDLE  = 12'b000000000010,
      S_RD    = 12'b000000000100,
      S_DEC   = 12'b000000001000,
      S_UNL1  = 12'b000000010000,
      S_UNL2  = 12'b000000100000,
      S_ENQ   = 12'b000001000000,
      S_ENQ2  = 12'b000010000000,
      S_SCAN  = 12'b000100000000,
      S_SW    = 12'b001000000000,
      S_SW2   = 12'b010000000000,
      S_DONE  = 12'b100000000000
   } state_type;

   // The task memories have separate write ports and may be written together at different addresses.
   state_type state_ff, state_in;
   logic [TWP-1:0] clr_ff, clr_in;
   logic [TASK_W-1:0] idle_ff;
   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [TW-1:0] t_ff, t_in;
   logic [PRIO_W-1:0] np_ff, np_in;
   logic [TW-1:0] cur_ff, cur_in;
   logic resched_ff, resched_in;
   logic [PRIORITY_LEVELS-1:0] bits_ff, bits_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [2:0] fl_ff, fl_in;
   logic [LW-1:0] pr_ff, pr_in, newl_ff, newl_in;
   logic [LW-1:0] curpr_ff, curpr_in;
   logic [TW-1:0] n_ff, n_in, p_ff, p_in;
   logic enq_after_ff, enq_after_in;
   logic [LW-1:0] scan_ff, scan_in;
   logic ovalid_ff, ovalid_in;
   logic [TW-1:0] orun_ff, orun_in;
   logic ores_ff, ores_in;
   logic [STATUS_W-1:0] ost_ff, ost_in;

   // memories
   logic f_we; logic [TW-1:0] f_wa, f_ra; logic [2:0] f_wd, f_rd;
   logic pm_we; logic [TW-1:0] pm_wa, pm_ra; logic [LW-1:0] pm_wd, pm_rd;
   logic nx_we; logic [TW-1:0] nx_wa, nx_ra, nx_wd, nx_rd;
   logic pv_we; logic [TW-1:0] pv_wa, pv_ra, pv_wd, pv_rd;
   logic hd_we; logic [LW-1:0] hd_wa, hd_ra; logic [TW-1:0] hd_wd, hd_rd;
   logic tl_we; logic [LW-1:0] tl_wa, tl_ra; logic [TW-1:0] tl_wd, tl_rd;

   pbrq_ram #(.WIDTH(3), .DEPTH(TASK_SLOTS)) u_flags (.clock, .we(f_we), .waddr(f_wa),
      .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
   pbrq_ram #(.WIDTH(LW), .DEPTH(TASK_SLOTS)) u_prio (.clock, .we(pm_we), .waddr(pm_wa),
      .wdata(pm_wd), .raddr(pm_ra), .rdata(pm_rd));
   pbrq_ram #(.WIDTH(TW), .DEPTH(TASK_SLOTS)) u_next (.clock, .we(nx_we), .waddr(nx_wa),
      .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
   pbrq_ram #(.WIDTH(TW), .DEPTH(TASK_SLOTS)) u_prev (.clock, .we(pv_we), .waddr(pv_wa),
      .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
   pbrq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_head (.clock, .we(hd_we),
      .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));
   pbrq_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_tail (.clock, .we(tl_we),
      .waddr(tl_wa), .wdata(tl_wd), .raddr(tl_ra), .rdata(tl_rd));

   logic [TW-1:0] idle_t, tid_slot;
   logic req_fire, rsp_fire, head_hit, tail_hit;

   assign tid_slot = slot_of(req.task_id);
   assign idle_t = slot_of(idle_ff);
   // The result register parts the two sides: a new transfer may start while the
   // previous result still waits, and the sequencer holds in its last step instead.
   assign req.ready = (state_ff == S_IDLE);
   assign req_fire = req.valid && req.ready;
   assign rsp_fire = rsp.valid && rsp.ready;
   assign rsp.valid = ovalid_ff;
   assign rsp.running_task = TASK_W'(orun_ff);
   assign rsp.resched_hint = ores_ff;
   assign rsp.status = ost_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(32-TASK_W){1'b0}}, idle_ff};
   assign head_hit = (hd_rd == t_ff);
   assign tail_hit = (tl_rd == t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0
                   && csr_paddr[1:0] == 2'b00) begin
         idle_ff <= csr_pwdata[TASK_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; op_in = op_ff; t_in = t_ff; np_in = np_ff;
      cur_in = cur_ff; resched_in = resched_ff; bits_in = bits_ff; st_in = st_ff;
      fl_in = fl_ff; pr_in = pr_ff; newl_in = newl_ff; curpr_in = curpr_ff;
      n_in = n_ff; p_in = p_ff; enq_after_in = enq_after_ff; scan_in = scan_ff;
      ovalid_in = ovalid_ff && !rsp_fire; orun_in = orun_ff; ores_in = ores_ff;
      ost_in = ost_ff;
      f_we = 1'b0; f_wa = t_ff; f_wd = fl_ff; f_ra = t_ff;
      pm_we = 1'b0; pm_wa = t_ff; pm_wd = newl_ff; pm_ra = t_ff;
      nx_we = 1'b0; nx_wa = t_ff; nx_wd = t_ff; nx_ra = t_ff;
      pv_we = 1'b0; pv_wa = t_ff; pv_wd = t_ff; pv_ra = t_ff;
      hd_we = 1'b0; hd_wa = pr_ff; hd_wd = t_ff; hd_ra = pr_ff;
      tl_we = 1'b0; tl_wa = pr_ff; tl_wd = t_ff; tl_ra = pr_ff;
      case (state_ff)
         S_CLEAR: begin
            // Task 0 starts queued at the idle level, the rest zero.
            f_we = 1'b1; f_wa = clr_ff[TW-1:0];
            f_wd = (clr_ff == '0) ? 3'b001 : 3'b000;
            pm_we = 1'b1; pm_wa = clr_ff[TW-1:0];
            pm_wd = (clr_ff == '0) ? IDLE_LVL : '0;
            hd_we = 1'b1; hd_wa = IDLE_LVL; hd_wd = '0;
            tl_we = 1'b1; tl_wa = IDLE_LVL; tl_wd = '0;
            nx_we = 1'b1; nx_wa = '0; nx_wd = '0;
            pv_we = 1'b1; pv_wa = '0; pv_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == TWP'(TASK_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            f_ra = tid_slot; pm_ra = tid_slot;
            if (req_fire) begin
               op_in = req.opcode; t_in = tid_slot; np_in = req.new_priority;
               newl_in = (PRIORITY_LEVELS <= (1 << PRIO_W) &&
                          32'(req.new_priority) >= PRIORITY_LEVELS) ? IDLE_LVL
                         : LW'(req.new_priority);
               st_in = ST_OK;
               state_in = S_RD;
            end
            pm_wa = cur_ff;
         end
         S_RD: begin
            // Memory reads of the task are valid now; also fetch current task level.
            fl_in = f_rd; pr_in = pm_rd;
            pm_ra = cur_ff;
            hd_ra = pm_rd; tl_ra = pm_rd;
            nx_ra = t_ff; pv_ra = t_ff;
            scan_in = '0;
            state_in = S_DEC;
         end
         S_DEC: begin
            curpr_in = pm_rd;
            n_in = nx_rd; p_in = pv_rd;
            hd_ra = pr_ff; tl_ra = pr_ff;
            enq_after_in = 1'b0;
            state_in = S_DONE;
            case (op_ff)
               OP_WAKE, OP_RESUME: begin
                  if ((op_ff == OP_WAKE) ? fl_ff[FLAG_S] : fl_ff[FLAG_W]) begin
                     fl_in = (op_ff == OP_WAKE) ? (fl_ff & 3'b101) : (fl_ff & 3'b011);
                     f_we = 1'b1; f_wd = fl_in;
                  end else begin
                     newl_in = pr_ff;
                     fl_in = fl_ff & 3'b001;
                     if (fl_ff[FLAG_Q]) begin
                        f_we = 1'b1; f_wd = fl_in;
                     end else begin
                        state_in = S_ENQ;
                     end
                  end
               end
               OP_BLOCK, OP_SUSPEND: begin
                  if (!fl_ff[FLAG_Q]) begin
                     fl_in = fl_ff | ((op_ff == OP_BLOCK) ? 3'b010 : 3'b100);
                     f_we = 1'b1; f_wd = fl_in;
                  end else if (t_ff == idle_t) begin
                     st_in = ST_IDLE_REF;
                  end else begin
                     fl_in = (fl_ff & 3'b110) | ((op_ff == OP_BLOCK) ? 3'b010 : 3'b100);
                     state_in = S_UNL1;
                  end
               end
               OP_CREATE: begin
                  if (32'(np_ff) >= PRIORITY_LEVELS - 1) begin
                     st_in = ST_RANGE;
                  end else if (fl_ff[FLAG_Q] && t_ff == idle_t) begin
                     st_in = ST_IDLE_REF;
                  end else begin
                     enq_after_in = 1'b1;
                     fl_in = '0;
                     state_in = fl_ff[FLAG_Q] ? S_UNL1 : S_ENQ;
                  end
               end
               OP_CHPRIO: begin
                  if (newl_ff != pr_ff) begin
                     if (!fl_ff[FLAG_Q]) begin
                        pm_we = 1'b1; pm_wd = newl_ff;
                     end else if (t_ff == idle_t) begin
                        st_in = ST_IDLE_REF;
                     end else begin
                        enq_after_in = 1'b1;
                        fl_in = fl_ff & 3'b110;
                        state_in = S_UNL1;
                     end
                  end
               end
               OP_SWITCH: begin
                  resched_in = 1'b0;
                  state_in = S_SCAN;
               end
               default: ;
            endcase
         end
         S_UNL1: begin
            // hd/tl of the old level are available; patch neighbors.
            if (head_hit && tail_hit) begin
               bits_in[pr_ff] = 1'b0;
            end else begin
               if (head_hit) begin hd_we = 1'b1; hd_wd = n_ff; end
               else begin nx_we = 1'b1; nx_wa = p_ff; nx_wd = n_ff; end
               if (tail_hit) begin tl_we = 1'b1; tl_wd = p_ff; end
               else begin pv_we = 1'b1; pv_wa = n_ff; pv_wd = p_ff; end
            end
            state_in = S_UNL2;
         end
         S_UNL2: begin
            f_we = 1'b1; f_wd = fl_ff;
            if (enq_after_ff) begin
               pm_we = 1'b1; pm_wd = newl_ff;
               pr_in = newl_ff;
               state_in = S_ENQ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ENQ: begin
            // Read the tail of the target level.
            f_we = 1'b1; f_wd = fl_ff | 3'b001;
            pm_we = 1'b1; pm_wd = newl_ff;
            pr_in = newl_ff;
            tl_ra = newl_ff;
            state_in = S_ENQ2;
         end
         S_ENQ2: begin
            if (bits_ff[pr_ff]) begin
               pv_we = 1'b1; pv_wd = tl_rd;
               nx_we = 1'b1; nx_wa = tl_rd; nx_wd = t_ff;
               tl_we = 1'b1; tl_wd = t_ff;
            end else begin
               hd_we = 1'b1; hd_wd = t_ff;
               tl_we = 1'b1; tl_wd = t_ff;
               pv_we = 1'b1; nx_we = 1'b1;
               bits_in[pr_ff] = 1'b1;
            end
            // A task being re-queued was the current one: compare against its new level.
            if (pr_ff < ((t_ff == cur_ff) ? pr_ff : curpr_ff)) resched_in = 1'b1;
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (bits_ff[scan_ff]) begin
               hd_ra = scan_ff;
               state_in = S_SW;
            end else if (scan_ff == IDLE_LVL) begin
               state_in = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_SW: begin
            hd_ra = scan_ff;
            state_in = S_SW2;
         end
         S_SW2: begin
            hd_ra = scan_ff;
            cur_in = hd_rd;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1; orun_in = cur_ff; ores_in = resched_ff; ost_in = st_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; cur_ff <= '0; resched_ff <= 1'b0;
         bits_ff <= PRIORITY_LEVELS'(1) << (PRIORITY_LEVELS - 1);
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; cur_ff <= cur_in;
         resched_ff <= resched_in; bits_ff <= bits_in; ovalid_ff <= ovalid_in;
      end
      op_ff <= op_in; t_ff <= t_in; np_ff <= np_in; st_ff <= st_in; fl_ff <= fl_in;
      pr_ff <= pr_in; newl_ff <= newl_in; curpr_ff <= curpr_in; n_ff <= n_in;
      p_ff <= p_in; enq_after_ff <= enq_after_in; scan_ff <= scan_in;
      orun_ff <= orun_in; ores_ff <= ores_in; ost_ff <= ost_in;
   end
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import pbrq_pkg::*;

   // Opcode 7 has no name in the package; the block must treat it as a no-op.
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

   // Per-task flag bits, as the run queue keeps them.
   localparam logic [2:0] FLAG_QUEUED  = 3'b001;
   localparam logic [2:0] FLAG_WAIT    = 3'b010;
   localparam logic [2:0] FLAG_STOPPED = 3'b100;

   localparam int NUM_TASKS  = 64;
   localparam int NUM_LEVELS = 32;
   localparam int IDLE_LEVEL = NUM_LEVELS - 1;
   localparam int RANDOM_OPS = 900;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [TASK_W-1:0]   running_task;
      logic                resched_hint;
      logic [STATUS_W-1:0] status;
   } sched_result_t;

   // One row of the directed table. A row either writes the idle task register
   // or sends one command. Where fixed is set, the expected result is the one
   // typed into the row rather than the one the predictor works out.
   typedef struct {
      bit                  is_cfg;
      logic [OPCODE_W-1:0] opcode;
      logic [TASK_W-1:0]   task_id;
      logic [PRIO_W-1:0]   new_priority;
      bit                  fixed;
      sched_result_t       want;
   } sched_row_t;

   logic clock;
   logic reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pbrq_req_if req_ch ();
   pbrq_rsp_if rsp_ch ();

   priority_bitmap_run_queue DUT (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The clock period is 2 ns. Stimulus moves on the falling edge, and the
   // design's outputs are looked at on the rising edge.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the run queue. Every accepted command is applied here
   // in order, and the result it should produce is queued for the checker.
   // ------------------------------------------------------------------
   logic [NUM_LEVELS-1:0] level_bits;
   logic [TASK_W-1:0]     level_first [NUM_LEVELS];
   logic [TASK_W-1:0]     level_last  [NUM_LEVELS];
   logic [TASK_W-1:0]     link_next   [NUM_TASKS];
   logic [TASK_W-1:0]     link_prev   [NUM_TASKS];
   logic [PRIO_W-1:0]     task_level  [NUM_TASKS];
   logic [2:0]            task_state  [NUM_TASKS];
   logic [TASK_W-1:0]     current_id;
   logic                  resched_pending;
   logic [TASK_W-1:0]     idle_id;
   // A task whose level was never set has no defined level, so wake, resume
   // and change priority are only ever sent to tasks that have one.
   bit                    level_known [NUM_TASKS];

   sched_result_t pending_results[$];
   int fail_count;
   int cycle_count;
   int rsp_hold_request;
   bit quiet_mode;

   function automatic void queue_task(input logic [TASK_W-1:0] t);
      logic [PRIO_W-1:0] l;
      l = task_level[t];
      if (task_state[t] & FLAG_QUEUED) return;
      if (level_bits[l]) begin
         link_prev[t] = level_last[l];
         link_next[level_last[l]] = t;
         level_last[l] = t;
      end else begin
         level_first[l] = t;
         level_last[l] = t;
         link_prev[t] = t;
         link_next[t] = t;
         level_bits[l] = 1'b1;
      end
      task_state[t] |= FLAG_QUEUED;
      if (task_level[t] < task_level[current_id]) resched_pending = 1'b1;
   endfunction

   // Takes a task off its level. The idle task is refused while queued.
   function automatic logic [STATUS_W-1:0] unqueue_task(input logic [TASK_W-1:0] t);
      logic [PRIO_W-1:0] l;
      logic [TASK_W-1:0] n;
      logic [TASK_W-1:0] p;
      bit was_first;
      bit was_last;
      if (!(task_state[t] & FLAG_QUEUED)) return ST_OK;
      if (t == idle_id) return ST_IDLE_REF;
      l = task_level[t];
      n = link_next[t];
      p = link_prev[t];
      was_first = (level_first[l] == t);
      was_last  = (level_last[l] == t);
      if (was_first && was_last) begin
         level_bits[l] = 1'b0;
      end else begin
         if (was_first) level_first[l] = n;
         else link_next[p] = n;
         if (was_last) level_last[l] = p;
         else link_prev[n] = p;
      end
      task_state[t] &= ~FLAG_QUEUED;
      return ST_OK;
   endfunction

   function automatic sched_result_t apply_command(input logic [OPCODE_W-1:0] op,
                                                   input logic [TASK_W-1:0] tid,
                                                   input logic [PRIO_W-1:0] np);
      sched_result_t r;
      logic [STATUS_W-1:0] st;
      logic [TASK_W-1:0] t;
      t = tid;
      st = ST_OK;
      case (op)
         OP_WAKE: begin
            if (task_state[t] & FLAG_STOPPED) begin
               task_state[t] &= ~FLAG_WAIT;
            end else begin
               queue_task(t);
               task_state[t] &= ~(FLAG_WAIT | FLAG_STOPPED);
            end
         end
         OP_BLOCK: begin
            st = unqueue_task(t);
            if (st == ST_OK) task_state[t] |= FLAG_WAIT;
         end
         OP_SUSPEND: begin
            st = unqueue_task(t);
            if (st == ST_OK) task_state[t] |= FLAG_STOPPED;
         end
         OP_RESUME: begin
            if (task_state[t] & FLAG_WAIT) begin
               task_state[t] &= ~FLAG_STOPPED;
            end else begin
               queue_task(t);
               task_state[t] &= ~(FLAG_WAIT | FLAG_STOPPED);
            end
         end
         OP_CREATE: begin
            if (np >= IDLE_LEVEL) begin
               st = ST_RANGE;
            end else begin
               st = unqueue_task(t);
               if (st == ST_OK) begin
                  task_state[t] = 3'b000;
                  task_level[t] = np;
                  level_known[t] = 1'b1;
                  queue_task(t);
               end
            end
         end
         OP_CHPRIO: begin
            if (np != task_level[t]) begin
               if (task_state[t] & FLAG_QUEUED) begin
                  st = unqueue_task(t);
                  if (st == ST_OK) begin
                     task_level[t] = np;
                     queue_task(t);
                  end
               end else begin
                  task_level[t] = np;
               end
            end
         end
         OP_SWITCH: begin
            // The most urgent nonempty level wins; with an empty bitmap the
            // current task stays as it is.
            for (int l = 0; l < NUM_LEVELS; l++) begin
               if (level_bits[l]) begin
                  current_id = level_first[l];
                  break;
               end
            end
            resched_pending = 1'b0;
         end
         default: ;
      endcase
      r.running_task = current_id;
      r.resched_hint = resched_pending;
      r.status = st;
      return r;
   endfunction

   function automatic void reset_shadow();
      level_bits = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         level_first[l] = '0;
         level_last[l] = '0;
      end
      for (int t = 0; t < NUM_TASKS; t++) begin
         link_next[t] = '0;
         link_prev[t] = '0;
         task_level[t] = '0;
         task_state[t] = 3'b000;
         level_known[t] = 1'b0;
      end
      task_level[0] = PRIO_W'(IDLE_LEVEL);
      task_state[0] = FLAG_QUEUED;
      level_known[0] = 1'b1;
      level_bits[IDLE_LEVEL] = 1'b1;
      current_id = '0;
      resched_pending = 1'b0;
      idle_id = '0;
   endfunction

   // ------------------------------------------------------------------
   // Result checker: every transfer on the result channel is compared
   // with the oldest outstanding expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      sched_result_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: task %0d resched %0b status %0d",
                   rsp_ch.running_task, rsp_ch.resched_hint, rsp_ch.status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.running_task !== want.running_task) begin
               $error("running_task expected %0d actual %0d",
                      want.running_task, rsp_ch.running_task);
               fail_count++;
            end
            if (rsp_ch.resched_hint !== want.resched_hint) begin
               $error("resched_hint expected %0b actual %0b",
                      want.resched_hint, rsp_ch.resched_hint);
               fail_count++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_ch.status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Result receiver. It stalls at random, mostly briefly, now and then
   // for a long while. When the stimulus asks for a hold-off, the receiver
   // counts it down here on its own, so the sender keeps offering commands
   // and the design has to back up and stall its input.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      static int hold_left = 0;
      static int stall_left = 0;
      int pick;
      if (rsp_hold_request > 0) begin
         hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (quiet_mode) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            stall_left = $urandom_range(2);
            rsp_ch.ready <= 1'b0;
         end else if (pick < 28) begin
            stall_left = $urandom_range(40, 15);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. Each one is entered and left at a falling edge.
   // ------------------------------------------------------------------
   task automatic send_command(input logic [OPCODE_W-1:0] op,
                               input logic [TASK_W-1:0] tid,
                               input logic [PRIO_W-1:0] np,
                               input bit fixed,
                               input sched_result_t want);
      sched_result_t r;
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.task_id <= tid;
      req_ch.new_priority <= np;
      do @(posedge clock); while (!req_ch.ready);
      // The transfer has happened at this edge; the shadow follows it.
      r = apply_command(op, tid, np);
      pending_results.push_back(fixed ? want : r);
      @(negedge clock);
   endtask

   task automatic sender_gap();
      int pick;
      int len;
      if (quiet_mode) return;
      pick = $urandom_range(99);
      if (pick < 55) len = 0;
      else if (pick < 93) len = $urandom_range(3, 1);
      else len = $urandom_range(30, 8);
      if (len > 0) begin
         req_ch.valid <= 1'b0;
         repeat (len) @(negedge clock);
      end
   endtask

   // Register writes wait until no command is outstanding. Every command gives
   // exactly one result, so an empty expectation queue means idle; a few
   // spare cycles cover the sequencer's last write-back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic write_idle_task(input logic [TASK_W-1:0] id);
      drain_results();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(4 * REG_IDLE_TASK);
      csr_pwdata <= 32'(id);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      idle_id = id;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Directed table. Task 0 is the idle task after reset, parked at the
   // least urgent level. The last rows move the idle role to a task that
   // is never queued, so the bitmap can be emptied completely.
   sched_row_t directed_rows[] = '{
      '{0, OP_SWITCH,  6'd0,  5'd0,  1, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_BLOCK,   6'd0,  5'd0,  1, '{6'd0, 1'b0, ST_IDLE_REF}},
      '{0, OP_CREATE,  6'd4,  5'd31, 1, '{6'd0, 1'b0, ST_RANGE}},
      '{0, OP_CREATE,  6'd1,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_CREATE,  6'd2,  5'd5,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_CREATE,  6'd63, 5'd30, 0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_WAKE,    6'd1,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_SWITCH,  6'd63, 5'd31, 0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_BLOCK,   6'd1,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_WAKE,    6'd1,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_SUSPEND, 6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_RESUME,  6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_BLOCK,   6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_SUSPEND, 6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_RESUME,  6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_WAKE,    6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_CHPRIO,  6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_CHPRIO,  6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_CHPRIO,  6'd63, 5'd31, 0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_UNUSED,  6'd5,  5'd7,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_BLOCK,   6'd5,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_CREATE,  6'd1,  5'd30, 0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_SWITCH,  6'd0,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{1, OP_SWITCH,  6'd5,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_BLOCK,   6'd0,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_BLOCK,   6'd1,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_SUSPEND, 6'd2,  5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_BLOCK,   6'd63, 5'd0,  0, '{6'd0, 1'b0, ST_OK}},
      '{0, OP_SWITCH,  6'd0,  5'd0,  0, '{6'd0, 1'b0, ST_OK}}
   };

   // Picks the task for a random command. Most traffic stays on a handful
   // of tasks so the level lists grow several entries deep.
   function automatic logic [TASK_W-1:0] pick_task();
      if ($urandom_range(99) < 80) return TASK_W'($urandom_range(9));
      return TASK_W'($urandom_range(63));
   endfunction

   initial begin
      logic [OPCODE_W-1:0] op;
      logic [TASK_W-1:0] tid;
      logic [PRIO_W-1:0] np;
      int pick;
      int guard;
      fail_count = 0;
      cycle_count = 0;
      rsp_hold_request = 0;
      quiet_mode = 1'b0;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_WAKE;
      req_ch.task_id = '0;
      req_ch.new_priority = '0;
      rsp_ch.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset_shadow();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The register is written once right away, during the clearing pass,
      // with its reset value.
      write_idle_task(6'd0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) begin
            write_idle_task(directed_rows[i].task_id);
         end else begin
            send_command(directed_rows[i].opcode, directed_rows[i].task_id,
                         directed_rows[i].new_priority, directed_rows[i].fixed,
                         directed_rows[i].want);
            sender_gap();
         end
      end

      // Random phase. The idle role moves between tasks every so often,
      // with both ends of the id range among the settings.
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (n % 150 == 0) begin
            case (n / 150)
               0: write_idle_task(6'd63);
               1: write_idle_task(6'd0);
               2: write_idle_task(TASK_W'($urandom_range(9)));
               3: write_idle_task(6'd63);
               default: write_idle_task(TASK_W'($urandom_range(63)));
            endcase
         end
         quiet_mode = (n >= 700 && n < 760);
         if (n == 300) rsp_hold_request = 300;
         if (n == 500 || n == 620) begin
            req_ch.valid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end

         pick = $urandom_range(99);
         tid = pick_task();
         np = PRIO_W'($urandom_range(31));
         if (pick < 15) op = OP_WAKE;
         else if (pick < 27) op = OP_BLOCK;
         else if (pick < 37) op = OP_SUSPEND;
         else if (pick < 49) op = OP_RESUME;
         else if (pick < 64) op = OP_CREATE;
         else if (pick < 74) op = OP_CHPRIO;
         else if (pick < 97) op = OP_SWITCH;
         else op = OP_UNUSED;
         // Commands that read a task's level go only to tasks that have one;
         // otherwise the task is created first.
         if ((op == OP_WAKE || op == OP_RESUME || op == OP_CHPRIO) && !level_known[tid]) begin
            op = OP_CREATE;
            np = PRIO_W'($urandom_range(30));
         end
         send_command(op, tid, np, 1'b0, '0);
         sender_gap();
      end

      req_ch.valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
